[rtl/suare_pkg.sv]
// ----------------------------------------------------------------------------
// suare_pkg: shared types and constants for the sensor register access engine
// Item and result payloads, item kinds, status codes and the command word
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package suare_pkg;

	// item kinds
	localparam logic [2:0] KIND_READ   = 3'd0;
	localparam logic [2:0] KIND_WRITE  = 3'd1;
	localparam logic [2:0] KIND_WDATA  = 3'd2;
	localparam logic [2:0] KIND_RXBYTE = 3'd3;
	localparam logic [2:0] KIND_TICK   = 3'd4;
	localparam logic [2:0] KIND_CALIB  = 3'd5;

	// status codes
	localparam logic [4:0] ST_NONE       = 5'd0;
	localparam logic [4:0] ST_OK         = 5'd1;
	localparam logic [4:0] ST_UNKNOWN    = 5'd11;
	localparam logic [4:0] ST_LEN_MISM   = 5'd12;
	localparam logic [4:0] ST_BUSY       = 5'd13;
	localparam logic [4:0] ST_ZERO_LEN   = 5'd14;
	localparam logic [4:0] ST_TIMEOUT    = 5'd15;
	localparam logic [4:0] ST_CALIB_LEN  = 5'd16;

	// link bytes
	localparam logic [7:0] SYNC_BYTE     = 8'hAA;
	localparam logic [7:0] DIR_WRITE     = 8'h00;
	localparam logic [7:0] DIR_READ      = 8'h01;
	localparam logic [7:0] HDR_READ_RESP = 8'hBB;
	localparam logic [7:0] HDR_STATUS    = 8'hEE;
	localparam logic [7:0] CALIB_MASK    = 8'hC0;
	localparam logic [7:0] SENSOR_ST_MAX = 8'h0A;

	// configuration registers
	localparam int         CFG_IDX_W       = 1;
	localparam int         CFG_DATA_W      = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_REG = 1'd1;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
	localparam logic [7:0]  CALIB_REG_RESET = 8'd53;

	// receive / request phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WDATA,
		PH_HDR,
		PH_PAY,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] reg_address;
		logic [7:0] length;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_final;
		logic       done_res;
		logic [4:0] status;
		logic       calibrated;
		logic       ready_res;
		logic       last;
	} res_t;

	// command word: an optional single result, then an optional 4-byte frame
	typedef struct packed {
		logic       pre_v;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_final;
		logic       done_res;
		logic [4:0] status;
		logic       calibrated;
		logic       frm_v;
		logic [7:0] frm_dir;
		logic [7:0] frm_reg;
		logic [7:0] frm_len;
		logic       ready;
	} cmd_t;

endpackage

[rtl/suare_front.sv]
// ----------------------------------------------------------------------------
// suare_front: request and receive parser
// Holds the protocol state, classifies each accepted item and emits one
// command word per item that causes results.
// ----------------------------------------------------------------------------
module suare_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  suare_pkg::item_t                       item,
	input  logic                                   cfg_we,
	input  logic [suare_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [suare_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                   cmd_valid,
	output suare_pkg::cmd_t                        cmd
);

	suare_pkg::phase_t phase_q, phase_d;
	logic        busy_q, busy_d;
	logic [7:0]  req_len_q, req_len_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic        hdr_ee_q, hdr_ee_d;
	logic        calib_q, calib_d;
	logic [15:0] wait_q, wait_d;
	logic [15:0] timeout_q;
	logic [7:0]  calib_addr_q;

	logic [7:0]  bl_dec;
	logic [15:0] wait_inc;
	logic [15:0] lim;
	logic [4:0]  sensor_st;
	logic [7:0]  b;

	assign b        = item.data_byte;
	assign bl_dec   = bytes_left_q - 8'd1;
	assign wait_inc = (wait_q != 16'hFFFF) ? wait_q + 16'd1 : wait_q;
	assign lim      = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
	assign sensor_st = (b >= 8'h01 && b <= suare_pkg::SENSOR_ST_MAX) ?
		b[4:0] : suare_pkg::ST_UNKNOWN;

	// classify the item and work out the next state
	always_comb begin
		phase_d      = phase_q;
		busy_d       = busy_q;
		req_len_d    = req_len_q;
		bytes_left_d = bytes_left_q;
		hdr_ee_d     = hdr_ee_q;
		calib_d      = calib_q;
		wait_d       = wait_q;
		cmd          = '0;
		case (item.kind)
			suare_pkg::KIND_READ, suare_pkg::KIND_WRITE, suare_pkg::KIND_CALIB: begin
				if (busy_q) begin
					cmd.pre_v    = 1'b1;
					cmd.done_res = 1'b1;
					cmd.status   = suare_pkg::ST_BUSY;
				end else if (item.kind != suare_pkg::KIND_CALIB && item.length == 8'd0) begin
					cmd.pre_v    = 1'b1;
					cmd.done_res = 1'b1;
					cmd.status   = suare_pkg::ST_ZERO_LEN;
				end else begin
					cmd.frm_v   = 1'b1;
					cmd.frm_dir = (item.kind == suare_pkg::KIND_WRITE) ?
						suare_pkg::DIR_WRITE : suare_pkg::DIR_READ;
					cmd.frm_reg = item.reg_address;
					cmd.frm_len = item.length;
					if (item.kind == suare_pkg::KIND_CALIB) begin
						calib_d     = 1'b1;
						cmd.frm_reg = calib_addr_q;
						cmd.frm_len = 8'd1;
					end
					busy_d = 1'b1;
					wait_d = '0;
					if (item.kind == suare_pkg::KIND_WRITE) begin
						req_len_d    = '0;
						bytes_left_d = item.length;
						hdr_ee_d     = 1'b0;
						phase_d      = suare_pkg::PH_WDATA;
					end else begin
						req_len_d = cmd.frm_len;
					end
				end
			end
			suare_pkg::KIND_WDATA: begin
				if (phase_q == suare_pkg::PH_WDATA) begin
					cmd.pre_v    = 1'b1;
					cmd.tx_valid = 1'b1;
					cmd.tx_byte  = b;
					wait_d       = '0;
					bytes_left_d = bl_dec;
					if (bl_dec == 8'd0) phase_d = suare_pkg::PH_IDLE;
				end
			end
			suare_pkg::KIND_RXBYTE: begin
				if (phase_q != suare_pkg::PH_WDATA) begin
					if (busy_q) wait_d = '0;
					case (phase_q)
						suare_pkg::PH_IDLE: begin
							if (b == suare_pkg::HDR_STATUS || b == suare_pkg::HDR_READ_RESP) begin
								hdr_ee_d = (b == suare_pkg::HDR_STATUS);
								phase_d  = suare_pkg::PH_HDR;
							end
						end
						suare_pkg::PH_HDR: begin
							phase_d  = suare_pkg::PH_IDLE;
							hdr_ee_d = 1'b0;
							if (hdr_ee_q) begin
								cmd.done_res = 1'b1;
								cmd.status   = sensor_st;
								if (busy_q) begin
									busy_d    = 1'b0;
									req_len_d = '0;
									wait_d    = '0;
									if (sensor_st != suare_pkg::ST_OK) calib_d = 1'b0;
									cmd.pre_v = 1'b1;
								end else begin
									cmd.pre_v = (sensor_st != suare_pkg::ST_OK);
								end
							end else if (busy_q && req_len_q != 8'd0 && b == req_len_q) begin
								bytes_left_d = b;
								phase_d      = suare_pkg::PH_PAY;
							end else begin
								if (busy_q) begin
									busy_d    = 1'b0;
									req_len_d = '0;
									calib_d   = 1'b0;
									wait_d    = '0;
								end
								bytes_left_d = b;
								if (b != 8'd0) phase_d = suare_pkg::PH_SKIP;
								cmd.pre_v    = 1'b1;
								cmd.done_res = 1'b1;
								cmd.status   = suare_pkg::ST_LEN_MISM;
							end
						end
						suare_pkg::PH_PAY: begin
							bytes_left_d = bl_dec;
							cmd.pre_v    = 1'b1;
							cmd.rx_valid = 1'b1;
							cmd.rx_byte  = b;
							if (bl_dec == 8'd0) begin
								phase_d      = suare_pkg::PH_IDLE;
								cmd.rx_final = 1'b1;
								cmd.done_res = 1'b1;
								cmd.status   = suare_pkg::ST_OK;
								if (calib_q) begin
									if (req_len_q != 8'd1) begin
										busy_d     = 1'b0;
										req_len_d  = '0;
										calib_d    = 1'b0;
										wait_d     = '0;
										cmd.status = suare_pkg::ST_CALIB_LEN;
									end else if ((b & suare_pkg::CALIB_MASK) ==
										suare_pkg::CALIB_MASK) begin
										busy_d         = 1'b0;
										req_len_d      = '0;
										calib_d        = 1'b0;
										wait_d         = '0;
										cmd.calibrated = 1'b1;
									end else begin
										// poll the calibration register again
										cmd.frm_v   = 1'b1;
										cmd.frm_dir = suare_pkg::DIR_READ;
										cmd.frm_reg = calib_addr_q;
										cmd.frm_len = 8'd1;
										req_len_d   = 8'd1;
										wait_d      = '0;
									end
								end else begin
									busy_d    = 1'b0;
									req_len_d = '0;
									wait_d    = '0;
								end
							end
						end
						suare_pkg::PH_SKIP: begin
							bytes_left_d = bl_dec;
							if (bl_dec == 8'd0) phase_d = suare_pkg::PH_IDLE;
						end
						default: begin
						end
					endcase
				end
			end
			suare_pkg::KIND_TICK: begin
				if (busy_q) begin
					wait_d = wait_inc;
					if (wait_inc >= lim) begin
						busy_d       = 1'b0;
						req_len_d    = '0;
						calib_d      = 1'b0;
						wait_d       = '0;
						phase_d      = suare_pkg::PH_IDLE;
						bytes_left_d = '0;
						hdr_ee_d     = 1'b0;
						cmd.pre_v    = 1'b1;
						cmd.done_res = 1'b1;
						cmd.status   = suare_pkg::ST_TIMEOUT;
					end
				end
			end
			default: begin
			end
		endcase
		cmd.ready = ~busy_d;
	end

	assign cmd_valid = accept && (cmd.pre_v || cmd.frm_v);

	// update protocol state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= suare_pkg::PH_IDLE;
			busy_q       <= 1'b0;
			req_len_q    <= '0;
			bytes_left_q <= '0;
			hdr_ee_q     <= 1'b0;
			calib_q      <= 1'b0;
			wait_q       <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			busy_q       <= busy_d;
			req_len_q    <= req_len_d;
			bytes_left_q <= bytes_left_d;
			hdr_ee_q     <= hdr_ee_d;
			calib_q      <= calib_d;
			wait_q       <= wait_d;
		end
	end

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= suare_pkg::TIMEOUT_RESET;
			calib_addr_q <= suare_pkg::CALIB_REG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == suare_pkg::CFG_TIMEOUT) timeout_q <= cfg_data;
			if (cfg_index == suare_pkg::CFG_CALIB_REG) calib_addr_q <= cfg_data[7:0];
		end
	end

endmodule

[rtl/suare_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// suare_cmd_fifo: command queue between front and back
// Small register queue; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module suare_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  suare_pkg::cmd_t wr_data,
	input  logic            rd_en,
	output suare_pkg::cmd_t rd_data,
	output logic            full,
	output logic            empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	suare_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (rd_en) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (wr_en && !rd_en) count_q <= count_q + CW'(1);
			else if (!wr_en && rd_en) count_q <= count_q - CW'(1);
		end
	end

endmodule

[rtl/suare_back.sv]
// ----------------------------------------------------------------------------
// suare_back: command expander and result register
// Turns each command into its result transfers, one per cycle while each result
// is popped as it appears, and holds the oldest result until it is popped.
// ----------------------------------------------------------------------------
module suare_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_avail,
	input  suare_pkg::cmd_t cmd,
	output logic            cmd_done,
	input  logic            pop,
	output logic            empty,
	output suare_pkg::res_t result
);

	logic [2:0]      step_q;
	logic            out_v_q;
	suare_pkg::res_t out_q;
	suare_pkg::res_t nxt;
	logic            load;
	logic            is_pre;
	logic [1:0]      idx;
	logic [2:0]      fidx;

	assign load   = cmd_avail && (!out_v_q || pop);
	assign is_pre = cmd.pre_v && (step_q == 3'd0);
	assign fidx   = cmd.pre_v ? step_q - 3'd1 : step_q;
	assign idx    = fidx[1:0];

	// build the next result of the head command
	always_comb begin
		nxt = '0;
		nxt.ready_res = cmd.ready;
		if (is_pre) begin
			nxt.tx_valid   = cmd.tx_valid;
			nxt.tx_byte    = cmd.tx_byte;
			nxt.rx_valid   = cmd.rx_valid;
			nxt.rx_byte    = cmd.rx_byte;
			nxt.rx_final   = cmd.rx_final;
			nxt.done_res   = cmd.done_res;
			nxt.status     = cmd.status;
			nxt.calibrated = cmd.calibrated;
			nxt.last       = ~cmd.frm_v;
		end else begin
			nxt.tx_valid = 1'b1;
			case (idx)
				2'd0:    nxt.tx_byte = suare_pkg::SYNC_BYTE;
				2'd1:    nxt.tx_byte = cmd.frm_dir;
				2'd2:    nxt.tx_byte = cmd.frm_reg;
				default: nxt.tx_byte = cmd.frm_len;
			endcase
			nxt.last = (idx == 2'd3);
		end
	end

	assign cmd_done = load && nxt.last;
	assign empty    = ~out_v_q;
	assign result   = out_q;

	// hold payload of the waiting result
	always_ff @(posedge clk) begin
		if (load) out_q <= nxt;
	end

	// advance step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				step_q  <= nxt.last ? 3'd0 : step_q + 3'd1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/sensor_uart_register_access_engine_unit.sv]
// An accepted item reaches its first result through the command queue, then
// the result register. Items are taken one per cycle while the command queue
// has room; results leave one per cycle while they are popped, so a request
// with its four frame bytes takes four results on the result side.
// Reset: protocol state idle and not busy, queue and result register empty,
// timeout_ticks 1000 and calib_reg_address 53.
// ----------------------------------------------------------------------------
// sensor_uart_register_access_engine_unit: sensor UART register access engine
// Front parser, command queue and result expander for the host side of the
// sensor register protocol.
// ----------------------------------------------------------------------------
module sensor_uart_register_access_engine_unit #(
	parameter int CMD_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  suare_pkg::item_t                  item,
	output logic                              empty,
	input  logic                              pop,
	output suare_pkg::res_t                   result,
	input  logic                              cfg_we,
	input  logic [suare_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [suare_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic            accept;
	logic            cmd_wr;
	suare_pkg::cmd_t cmd_in;
	suare_pkg::cmd_t cmd_head;
	logic            q_empty;
	logic            cmd_done;

	assign accept = push && !full;

	suare_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_wr),
		.cmd       (cmd_in)
	);

	suare_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd_in),
		.rd_en   (cmd_done),
		.rd_data (cmd_head),
		.full    (full),
		.empty   (q_empty)
	);

	suare_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (~q_empty),
		.cmd       (cmd_head),
		.cmd_done  (cmd_done),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
